>>> hdl/pmnr_pkg.sv
// Shared constants, widths and helper functions for the PLL divider search.
package pmnr_pkg;

    localparam int F_W      = 30;
    localparam int REF_W    = 27;
    localparam int FS_W     = F_W + 3;
    localparam int STEP_W   = 29;
    localparam int FD_W     = 34;
    localparam int PROD_W   = REF_W + 8;
    localparam int M_W      = 7;
    localparam int N_W      = 5;
    localparam int R_W      = 2;
    localparam int WORD_W   = 15;

    localparam logic [FS_W-1:0]  PLL_LOW_HZ   = FS_W'(135000000);
    localparam logic [FS_W-1:0]  PLL_HIGH_HZ  = FS_W'(270000000);
    localparam logic [F_W-1:0]   FALLBACK_HZ  = F_W'(25000000);
    localparam logic [REF_W-1:0] REF_RESET_HZ = REF_W'(14318180);
    localparam logic [N_W-1:0]   N_FIRST      = N_W'(1);
    localparam logic [N_W-1:0]   N_LAST       = N_W'(31);

    typedef struct packed {
        logic            found;
        logic [R_W-1:0]  r;
    } rsel_t;

    // First post-divider exponent that puts f * 2^R into (135 MHz, 270 MHz]
    function automatic rsel_t r_select(logic [F_W-1:0] f);
        rsel_t           res;
        logic [FS_W-1:0] fs;
        res.found = 1'b0;
        res.r     = '0;
        for (int i = 0; i < 4; i++)
        begin
            fs = FS_W'(f) << i;
            if (!res.found && fs > PLL_LOW_HZ && fs <= PLL_HIGH_HZ)
            begin
                res.found = 1'b1;
                res.r     = R_W'(i);
            end
        end
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] pack_word(logic [M_W-1:0] m, logic [R_W-1:0] r,
                                                    logic [N_W-1:0] n);
        return {m, 1'b0, r, n};
    endfunction

endpackage

>>> hdl/pmnr_if.sv
// Handshake channel interfaces: target request, divider result and reference configuration.
interface pmnr_req_if;
    import pmnr_pkg::*;
    logic             valid;
    logic             ready;
    logic [F_W-1:0]   target_freq_hz;
    modport source (output valid, output target_freq_hz, input ready);
    modport sink   (input valid, input target_freq_hz, output ready);
endinterface

interface pmnr_rsp_if;
    import pmnr_pkg::*;
    logic              valid;
    logic              ready;
    logic [M_W-1:0]    m_div;
    logic [N_W-1:0]    n_div;
    logic [R_W-1:0]    r_shift;
    logic [WORD_W-1:0] clock_word;
    logic              used_fallback;
    modport source (output valid, output m_div, output n_div, output r_shift,
                    output clock_word, output used_fallback, input ready);
    modport sink   (input valid, input m_div, input n_div, input r_shift,
                    input clock_word, input used_fallback, output ready);
endinterface

interface pmnr_cfg_if;
    import pmnr_pkg::*;
    logic             valid;
    logic             ready;
    logic [REF_W-1:0] ref_freq_hz;
    modport source (output valid, output ref_freq_hz, input ready);
    modport sink   (input valid, input ref_freq_hz, output ready);
endinterface

>>> hdl/pmnr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module pmnr_div
    import pmnr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [FD_W-1:0]  dividend,
    input  logic [REF_W-1:0] divisor,
    output logic             done,
    output logic [FD_W-1:0]  quotient,
    output logic [REF_W-1:0] remainder
);

    localparam int CNT_W = $clog2(FD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [FD_W-1:0]  quo_reg, quo_next;
    logic [REF_W-1:0] rem_reg, rem_next;

    logic [REF_W:0]   shifted;
    logic [REF_W:0]   diff;
    logic             ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[FD_W-1]};
        diff      = shifted - {1'b0, divisor};
        ge        = shifted >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(FD_W);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[REF_W-1:0] : shifted[REF_W-1:0];
            quo_next = {quo_reg[FD_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/pll_mnr_divider_search.sv
// Top level: PLL M/N/R divider search sequencer around a shared divider.
//
// Usage: a target frequency in Hz arrives as one transaction on req. The
// block picks the post divider R, then tries N = 1..31 in turn; each trial
// runs one division of f*(N+2)*2^R by the reference frequency through the
// shared bit-serial divider; each N tried is a load, the 34 quotient bits,
// completion and a tolerance check. If no R or N fits, the same search runs
// for 25 MHz with used_fallback set. req.ready is high only while no search
// runs, so one item is handled at a time.
// The result sits in an output register on rsp; a stalled receiver holds it
// there, and the next request may be accepted and searched meanwhile; the
// following result waits until rsp is taken.
// cfg writes the reference frequency, always ready; write it only while idle.
// Reset: the reference returns to 14318180 Hz, no result pending, idle.
module pll_mnr_divider_search
    import pmnr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pmnr_req_if.sink    req,
    pmnr_rsp_if.source  rsp,
    pmnr_cfg_if.sink    cfg
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEL   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [REF_W-1:0]  ref_reg, ref_next;
    logic [F_W-1:0]    freq_reg, freq_next;
    logic              fb_reg, fb_next;
    logic [R_W-1:0]    r_reg, r_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [M_W-1:0]    m_reg, m_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [FD_W-1:0]   fd_reg, fd_next;

    logic              out_valid_reg, out_valid_next;
    logic [M_W-1:0]    out_m_reg, out_m_next;
    logic [N_W-1:0]    out_n_reg, out_n_next;
    logic [R_W-1:0]    out_r_reg, out_r_next;
    logic              out_fb_reg, out_fb_next;

    logic              div_start;
    logic              div_done;
    logic [FD_W-1:0]   quotient;
    logic [REF_W-1:0]  remainder;

    rsel_t             rsel;
    logic [FS_W-1:0]   fs;
    logic [PROD_W-1:0] rem_x200;
    logic [FD_W-1:0]   m_full;
    logic              fit;
    logic              search_fail;

    pmnr_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (fd_reg),
        .divisor   (ref_reg),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_comb
    begin
        rsel     = r_select(freq_reg);
        fs       = FS_W'(freq_reg) << rsel.r;
        rem_x200 = (PROD_W'(remainder) << 7) + (PROD_W'(remainder) << 6)
                 + (PROD_W'(remainder) << 3);
        m_full   = quotient - FD_W'(2);
        // q*Fref = fd - rem, so the +-0.5% window reduces to 200*rem < fd
        fit      = (quotient >= FD_W'(2)) && (rem_x200 < PROD_W'(fd_reg));
    end

    always_comb
    begin
        state_next     = state_reg;
        ref_next       = ref_reg;
        freq_next      = freq_reg;
        fb_next        = fb_reg;
        r_next         = r_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        step_next      = step_reg;
        fd_next        = fd_reg;
        out_valid_next = out_valid_reg;
        out_m_next     = out_m_reg;
        out_n_next     = out_n_reg;
        out_r_next     = out_r_reg;
        out_fb_next    = out_fb_reg;
        div_start      = 1'b0;
        search_fail    = 1'b0;

        if (cfg.valid)
        begin
            ref_next = cfg.ref_freq_hz;
        end
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    freq_next  = req.target_freq_hz;
                    fb_next    = 1'b0;
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                if (!rsel.found || ref_reg == '0)
                begin
                    search_fail = 1'b1;
                end
                else
                begin
                    r_next     = rsel.r;
                    n_next     = N_FIRST;
                    step_next  = fs[STEP_W-1:0];
                    fd_next    = (FD_W'(fs[STEP_W-1:0]) << 1) + FD_W'(fs[STEP_W-1:0]);
                    state_next = S_START;
                end
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (fit)
                begin
                    m_next     = m_full[M_W-1:0];
                    state_next = S_DONE;
                end
                else if (n_reg == N_LAST)
                begin
                    search_fail = 1'b1;
                end
                else
                begin
                    n_next     = n_reg + N_W'(1);
                    fd_next    = fd_reg + FD_W'(step_reg);
                    state_next = S_START;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_m_next     = m_reg;
                    out_n_next     = n_reg;
                    out_r_next     = r_reg;
                    out_fb_next    = fb_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (search_fail)
        begin
            if (fb_reg)
            begin
                m_next     = '0;
                n_next     = '0;
                r_next     = '0;
                state_next = S_DONE;
            end
            else
            begin
                freq_next  = FALLBACK_HZ;
                fb_next    = 1'b1;
                state_next = S_SEL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ref_reg       <= REF_RESET_HZ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ref_reg       <= ref_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg   <= freq_next;
        fb_reg     <= fb_next;
        r_reg      <= r_next;
        n_reg      <= n_next;
        m_reg      <= m_next;
        step_reg   <= step_next;
        fd_reg     <= fd_next;
        out_m_reg  <= out_m_next;
        out_n_reg  <= out_n_next;
        out_r_reg  <= out_r_next;
        out_fb_reg <= out_fb_next;
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign rsp.valid         = out_valid_reg;
    assign rsp.m_div         = out_m_reg;
    assign rsp.n_div         = out_n_reg;
    assign rsp.r_shift       = out_r_reg;
    assign rsp.clock_word    = pack_word(out_m_reg, out_r_reg, out_n_reg);
    assign rsp.used_fallback = out_fb_reg;

endmodule
